/* rtl/core/point_in_polygon_ray_cast_macros.svh */
// Assertion macros shared by the point-in-polygon modules.
// Each macro expands to one labeled concurrent assertion that is
// clocked on the rising edge and disabled while reset is high.
`ifndef POINT_IN_POLYGON_RAY_CAST_MACROS_SVH
`define POINT_IN_POLYGON_RAY_CAST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PIP_ASSERT_NOW(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define PIP_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

/* rtl/core/pip_pkg.sv */
`default_nettype none

package pip_pkg;

  // Sequencer states: accept a vertex, left and right multiply, update, result.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LHS,
    ST_RHS,
    ST_DECIDE,
    ST_EMIT
  } pip_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic mul_lhs;
    logic mul_rhs;
    logic decide;
    logic emit;
  } pip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last;
    logic out_free;
  } pip_status_t;

endpackage

`default_nettype wire

/* rtl/core/pip_if.sv */
`default_nettype none

// Vertex stream: one polygon vertex per transfer.
interface pip_vertex_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] vertex_x;
  logic signed [COORD_BITS-1:0] vertex_y;
  logic                         first_vertex;
  logic                         last_vertex;

  modport source (
    output valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, vertex_x, vertex_y, first_vertex, last_vertex,
    output ready
  );
endinterface

// Verdict stream: one transfer per polygon.
interface pip_result_if;
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

`default_nettype wire

/* rtl/core/pip_datapath.sv */
`default_nettype none
`include "point_in_polygon_ray_cast_macros.svh"

module pip_datapath #(
  parameter int COORD_BITS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire pip_pkg::pip_cmd_t            cmd,
  output pip_pkg::pip_status_t              status,
  input  wire logic signed [COORD_BITS-1:0] point_x,
  input  wire logic signed [COORD_BITS-1:0] point_y,
  input  wire logic signed [COORD_BITS-1:0] vertex_x,
  input  wire logic signed [COORD_BITS-1:0] vertex_y,
  input  wire logic                         first_vertex,
  input  wire logic                         last_vertex,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              inside_res
);

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  logic signed [COORD_BITS-1:0] query_x;
  logic signed [COORD_BITS-1:0] query_y;
  logic signed [COORD_BITS-1:0] prev_x;
  logic signed [COORD_BITS-1:0] prev_y;
  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic                         have_prev;
  logic                         edge_en;
  logic                         last_r;
  logic                         crossing_parity;
  logic                         boundary_hit;
  logic signed [PW-1:0]         lhs;
  logic signed [PW-1:0]         rhs;

  logic signed [DW-1:0] dx_pt;
  logic signed [DW-1:0] dy_pt;
  logic signed [DW-1:0] dx_edge;
  logic signed [DW-1:0] dy_edge;
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [PW-1:0] prod;

  logic signed [COORD_BITS-1:0] min_x;
  logic signed [COORD_BITS-1:0] max_x;
  logic signed [COORD_BITS-1:0] min_y;
  logic signed [COORD_BITS-1:0] max_y;
  logic vert_match;
  logic horiz_hit;
  logic span;
  logic prod_eq;
  logic prod_lt;
  logic prod_gt;
  logic toggle;

  // Edge differences, one bit wider so they never overflow.
  assign dx_pt   = $signed({query_x[COORD_BITS-1], query_x}) - $signed({prev_x[COORD_BITS-1], prev_x});
  assign dy_pt   = $signed({query_y[COORD_BITS-1], query_y}) - $signed({prev_y[COORD_BITS-1], prev_y});
  assign dx_edge = $signed({cur_x[COORD_BITS-1], cur_x}) - $signed({prev_x[COORD_BITS-1], prev_x});
  assign dy_edge = $signed({cur_y[COORD_BITS-1], cur_y}) - $signed({prev_y[COORD_BITS-1], prev_y});

  // One shared multiplier: (py - y1) * (x2 - x1) first, then (px - x1) * (y2 - y1).
  assign mul_a = cmd.mul_rhs ? dx_pt : dy_pt;
  assign mul_b = cmd.mul_rhs ? dy_edge : dx_edge;
  assign prod  = mul_a * mul_b;

  // Edge bounds and the boundary and crossing tests.
  assign min_x = (prev_x < cur_x) ? prev_x : cur_x;
  assign max_x = (prev_x < cur_x) ? cur_x : prev_x;
  assign min_y = (prev_y < cur_y) ? prev_y : cur_y;
  assign max_y = (prev_y < cur_y) ? cur_y : prev_y;

  assign vert_match = (cur_x == query_x) && (cur_y == query_y);
  assign horiz_hit  = edge_en && (prev_y == cur_y) && (prev_y == query_y)
                      && (query_x > min_x) && (query_x < max_x);
  assign span       = edge_en && (query_y > min_y) && (query_y <= max_y)
                      && (query_x <= max_x) && (prev_y != cur_y);
  assign prod_eq    = (rhs == lhs);
  assign prod_lt    = (rhs < lhs);
  assign prod_gt    = !prod_eq && !prod_lt;
  assign toggle     = span && !prod_eq
                      && ((prev_x == cur_x) || ((dy_edge > 0) ? prod_lt : prod_gt));

  // Polygon state: cleared by a first vertex, updated once per vertex.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x         <= '0;
      query_y         <= '0;
      have_prev       <= 1'b0;
      edge_en         <= 1'b0;
      last_r          <= 1'b0;
      crossing_parity <= 1'b0;
      boundary_hit    <= 1'b0;
    end else if (cmd.load) begin
      last_r  <= last_vertex;
      edge_en <= have_prev && !first_vertex;
      if (first_vertex) begin
        query_x         <= point_x;
        query_y         <= point_y;
        crossing_parity <= 1'b0;
        boundary_hit    <= 1'b0;
      end
    end else if (cmd.decide) begin
      have_prev       <= 1'b1;
      crossing_parity <= crossing_parity ^ toggle;
      boundary_hit    <= boundary_hit || vert_match || horiz_hit || (span && prod_eq);
    end
  end

  // Vertex and product registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x <= vertex_x;
      cur_y <= vertex_y;
    end
    if (cmd.decide) begin
      prev_x <= cur_x;
      prev_y <= cur_y;
    end
    if (cmd.mul_lhs) begin
      lhs <= prod;
    end
    if (cmd.mul_rhs) begin
      rhs <= prod;
    end
  end

  // Output register holds the verdict until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      inside_res <= boundary_hit || crossing_parity;
    end
  end

  assign status.last     = last_r;
  assign status.out_free = !out_valid || out_ready;

  `PIP_ASSERT_NEXT(a_vertex_hit, clk, rst, cmd.decide && vert_match, boundary_hit)
  `PIP_ASSERT_NEXT(a_first_clears, clk, rst, cmd.load && first_vertex, !crossing_parity && !edge_en)
  `PIP_ASSERT_NEXT(a_emit_valid, clk, rst, cmd.emit, out_valid && (inside_res == (boundary_hit || crossing_parity)))

endmodule

`default_nettype wire

/* rtl/core/pip_ctrl.sv */
`default_nettype none
`include "point_in_polygon_ray_cast_macros.svh"

module pip_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pip_pkg::pip_status_t status,
  output pip_pkg::pip_cmd_t         cmd
);

  pip_pkg::pip_state_t state;
  pip_pkg::pip_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pip_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  // No vertex is taken while reset is held, so none can be lost there.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      pip_pkg::ST_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = pip_pkg::ST_LHS;
        end
      end
      pip_pkg::ST_LHS: begin
        cmd.mul_lhs = 1'b1;
        state_next  = pip_pkg::ST_RHS;
      end
      pip_pkg::ST_RHS: begin
        cmd.mul_rhs = 1'b1;
        state_next  = pip_pkg::ST_DECIDE;
      end
      pip_pkg::ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.last ? pip_pkg::ST_EMIT : pip_pkg::ST_IDLE;
      end
      pip_pkg::ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = pip_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pip_pkg::ST_IDLE;
      end
    endcase
  end

  `PIP_ASSERT_NOW(a_emit_free, clk, rst, cmd.emit, status.out_free)
  `PIP_ASSERT_NEXT(a_one_item, clk, rst, cmd.load, !in_ready && cmd.mul_lhs)
  `PIP_ASSERT_NEXT(a_no_result_ready, clk, rst, cmd.decide && !status.last, in_ready)

endmodule

`default_nettype wire

/* rtl/core/point_in_polygon_ray_cast.sv */
// Point-in-polygon test by ray casting, one vertex per transfer.
// A new vertex is taken only once the last one is through; one shared multiplier
// forms both cross products of an edge in turn, then the state is updated.
// A last vertex then goes on to the emit state, which registers the verdict,
// or waits there while the previous verdict has not been taken.
// Reset (rst, synchronous): query point, parity and hit flags and valids clear.
`default_nettype none

module point_in_polygon_ray_cast #(
  parameter int COORD_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  pip_vertex_if.sink  vtx,
  pip_result_if.source res
);

  pip_pkg::pip_cmd_t    cmd;
  pip_pkg::pip_status_t status;
  logic                 in_ready;

  assign vtx.ready = in_ready;

  // Sequencer.
  pip_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (vtx.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Edge arithmetic and polygon state.
  pip_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .point_x      (vtx.point_x),
    .point_y      (vtx.point_y),
    .vertex_x     (vtx.vertex_x),
    .vertex_y     (vtx.vertex_y),
    .first_vertex (vtx.first_vertex),
    .last_vertex  (vtx.last_vertex),
    .out_valid    (res.valid),
    .out_ready    (res.ready),
    .inside_res   (res.inside_res)
  );

endmodule

`default_nettype wire

/* tb/sv/point_in_polygon_ray_cast_test.sv */
`timescale 1ns / 1ps

module point_in_polygon_ray_cast_test;

  localparam int COORD_BITS = 32;
  localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 1850;
  localparam int SETTLE_CYCLES = 20;

  // Coordinate ranges used to build random polygons.
  typedef enum int {
    SPAN_TINY,
    SPAN_SMALL,
    SPAN_WIDE,
    SPAN_EXTREME
  } coord_span_t;

  // Stall patterns of the verdict receiver.
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY_THIRD,
    RX_LONG_STALL
  } rx_pattern_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic               first;
    logic               last;
    bit                 drain;
  } vertex_item_t;

  logic clk = 1'b0;
  logic rst;

  pip_vertex_if #(.COORD_BITS(COORD_BITS)) vertex_ch();
  pip_result_if verdict_ch();

  point_in_polygon_ray_cast #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .vtx(vertex_ch),
    .res(verdict_ch)
  );

  always #1 clk = ~clk;

  vertex_item_t vertex_pending[$];
  bit           inside_expected[$];
  vertex_item_t cur_item;
  int           item_total;
  int           error_count;

  // Running state of the ray-cast predictor.
  logic signed [31:0] query_x, query_y, prev_vx, prev_vy;
  bit have_prev, cross_odd, on_boundary;

  // Checks one edge against the query point: boundary hit or ray crossing.
  function automatic void trace_edge(input logic signed [31:0] x1, y1, x2, y2);
    logic signed [67:0] ax, ay, bx, by, qx, qy;
    logic signed [67:0] minx, maxx, miny, maxy, dy, lhs, rhs;
    ax = x1;
    ay = y1;
    bx = x2;
    by = y2;
    qx = query_x;
    qy = query_y;
    minx = (ax < bx) ? ax : bx;
    maxx = (ax < bx) ? bx : ax;
    miny = (ay < by) ? ay : by;
    maxy = (ay < by) ? by : ay;
    // A point strictly inside a horizontal edge lies on the boundary.
    if (ay == by && ay == qy && qx > minx && qx < maxx) begin
      on_boundary = 1'b1;
    end
    // Exact crossing test by cross-multiplication instead of a division.
    if (qy > miny && qy <= maxy && qx <= maxx && ay != by) begin
      dy = by - ay;
      lhs = (qy - ay) * (bx - ax);
      rhs = (qx - ax) * dy;
      if (rhs == lhs) begin
        on_boundary = 1'b1;
      end else if (ax == bx || ((dy > 0) ? (rhs < lhs) : (rhs > lhs))) begin
        cross_odd = ~cross_odd;
      end
    end
  endfunction

  // Advances the predictor by one vertex; returns 1 when a verdict is due.
  function automatic bit ray_cast_step(input vertex_item_t it, output bit verdict);
    if (it.first) begin
      query_x = it.px;
      query_y = it.py;
      have_prev = 1'b0;
      cross_odd = 1'b0;
      on_boundary = 1'b0;
    end
    if (it.vx == query_x && it.vy == query_y) begin
      on_boundary = 1'b1;
    end
    if (have_prev) begin
      trace_edge(prev_vx, prev_vy, it.vx, it.vy);
    end
    prev_vx = it.vx;
    prev_vy = it.vy;
    have_prev = 1'b1;
    verdict = on_boundary | cross_odd;
    return it.last;
  endfunction

  function automatic logic signed [31:0] rand_coord(input coord_span_t span);
    int v;
    case (span)
      SPAN_TINY: begin
        v = $urandom_range(0, 8);
        return v - 4;
      end
      SPAN_SMALL: begin
        v = $urandom_range(0, 128);
        return v - 64;
      end
      SPAN_WIDE: begin
        return $urandom;
      end
      default: begin
        case ($urandom_range(0, 6))
          0: return COORD_MIN;
          1: return COORD_MAX;
          2: return COORD_MIN + 1;
          3: return COORD_MAX - 1;
          4: return -1;
          5: return 1;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  task automatic put_vertex(input logic signed [31:0] px, py, vx, vy,
                            input logic first, last, input bit drain = 1'b0);
    vertex_item_t it;
    it.px = px;
    it.py = py;
    it.vx = vx;
    it.vy = vy;
    it.first = first;
    it.last = last;
    it.drain = drain;
    vertex_pending.push_back(it);
    item_total++;
  endtask

  // One random polygon: mostly closed and well marked, sometimes broken or noise.
  task automatic add_polygon();
    coord_span_t span;
    logic signed [31:0] px, py, x0, y0, vx, vy;
    int shape, n;
    bit drop_first, drop_last, drain;
    span = coord_span_t'($urandom_range(0, 3));
    shape = $urandom_range(0, 19);
    px = rand_coord(span);
    py = rand_coord(span);
    drop_first = (shape == 16);
    drop_last = (shape == 17);
    drain = ($urandom_range(0, 39) == 0);
    if (shape == 18) begin
      // A polygon of one vertex.
      put_vertex(px, py, rand_coord(span), rand_coord(span), 1'b1, 1'b1, drain);
    end else if (shape == 19) begin
      // Noise: random marks, random coordinates.
      n = $urandom_range(1, 5);
      for (int i = 0; i < n; i++) begin
        put_vertex($urandom, $urandom, rand_coord(span), rand_coord(span),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end
    end else begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(2, 7);
      x0 = rand_coord(span);
      y0 = rand_coord(span);
      put_vertex(px, py, x0, y0, !drop_first, 1'b0, drain);
      for (int i = 1; i < n; i++) begin
        vx = rand_coord(span);
        vy = rand_coord(span);
        put_vertex($urandom, $urandom, vx, vy, 1'b0, 1'b0);
      end
      // The caller closes the polygon by repeating the first vertex.
      put_vertex($urandom, $urandom, x0, y0, 1'b0, !drop_last);
    end
  endtask

  // Vertex driver: bursts of random length with random gaps between them.
  int gap_left;
  int burst_left;

  always @(posedge clk) begin
    bit verdict;
    bit launch;
    if (rst) begin
      vertex_ch.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      launch = 1'b0;
      if (vertex_ch.valid && vertex_ch.ready) begin
        if (ray_cast_step(cur_item, verdict)) begin
          inside_expected.push_back(verdict);
        end
      end
      if (!vertex_ch.valid || vertex_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (vertex_pending.size() > 0 &&
                     !(vertex_pending[0].drain && inside_expected.size() > 0)) begin
          launch = 1'b1;
        end
      end
      if (launch) begin
        cur_item = vertex_pending.pop_front();
        vertex_ch.valid <= 1'b1;
        vertex_ch.point_x <= cur_item.px;
        vertex_ch.point_y <= cur_item.py;
        vertex_ch.vertex_x <= cur_item.vx;
        vertex_ch.vertex_y <= cur_item.vy;
        vertex_ch.first_vertex <= cur_item.first;
        vertex_ch.last_vertex <= cur_item.last;
        if (burst_left > 0) begin
          burst_left--;
        end
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else if (!vertex_ch.valid || vertex_ch.ready) begin
        vertex_ch.valid <= 1'b0;
      end
    end
  end

  // Verdict receiver: ready follows a pattern that changes now and then.
  rx_pattern_t rx_pattern;
  int pattern_left;
  int rx_phase;

  always @(posedge clk) begin
    if (rst) begin
      verdict_ch.ready <= 1'b0;
      rx_pattern = RX_ALWAYS;
      pattern_left = 0;
      rx_phase = 0;
    end else begin
      if (pattern_left == 0) begin
        rx_pattern = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 300);
      end else begin
        pattern_left--;
      end
      rx_phase++;
      case (rx_pattern)
        RX_ALWAYS: verdict_ch.ready <= 1'b1;
        RX_COIN: verdict_ch.ready <= $urandom_range(0, 1);
        RX_EVERY_THIRD: verdict_ch.ready <= (rx_phase % 3) == 0;
        default: verdict_ch.ready <= (rx_phase % 24) < 4;
      endcase
    end
  end

  // Verdict monitor: each transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    bit want;
    if (!rst && verdict_ch.valid && verdict_ch.ready) begin
      if (inside_expected.size() == 0) begin
        $error("inside_res: expected none, actual %0d", verdict_ch.inside_res);
        error_count++;
      end else begin
        want = inside_expected.pop_front();
        if (verdict_ch.inside_res !== want) begin
          $error("inside_res: expected %0d, actual %0d", want, verdict_ch.inside_res);
          error_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    rst = 1'b1;
    vertex_ch.valid = 1'b0;
    vertex_ch.point_x = '0;
    vertex_ch.point_y = '0;
    vertex_ch.vertex_x = '0;
    vertex_ch.vertex_y = '0;
    vertex_ch.first_vertex = 1'b0;
    vertex_ch.last_vertex = 1'b0;
    verdict_ch.ready = 1'b0;
    item_total = 0;
    error_count = 0;
    query_x = '0;
    query_y = '0;
    prev_vx = '0;
    prev_vy = '0;
    have_prev = 1'b0;
    cross_odd = 1'b0;
    on_boundary = 1'b0;

    // No first mark after reset: the point stays at the origin.
    put_vertex(COORD_MAX, COORD_MIN, 0, 0, 1'b0, 1'b1);
    // One-vertex polygons, off the point and on it at the extremes.
    put_vertex(5, 5, 5, 6, 1'b1, 1'b1);
    put_vertex(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b1);
    // Square around the point, entered only once the earlier verdicts are in.
    put_vertex(5, 5, 0, 0, 1'b1, 1'b0, 1'b1);
    put_vertex(0, 0, 10, 0, 1'b0, 1'b0);
    put_vertex(0, 0, 10, 10, 1'b0, 1'b0);
    put_vertex(0, 0, 0, 10, 1'b0, 1'b0);
    put_vertex(0, 0, 0, 0, 1'b0, 1'b1);
    // Point on a horizontal edge, with a repeated vertex.
    put_vertex(5, 0, 0, 0, 1'b1, 1'b0);
    put_vertex(0, 0, 0, 0, 1'b0, 1'b0);
    put_vertex(0, 0, 10, 0, 1'b0, 1'b0);
    put_vertex(0, 0, 5, 10, 1'b0, 1'b0);
    put_vertex(0, 0, 0, 0, 1'b0, 1'b1);
    // Full-range triangle with the point at the far corner of the coordinate range.
    put_vertex(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    put_vertex(-1, -1, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
    put_vertex(-1, -1, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
    put_vertex(-1, -1, COORD_MIN, COORD_MIN, 1'b0, 1'b1);
    // The polygon goes on after its last mark.
    put_vertex(0, 0, COORD_MAX, COORD_MAX, 1'b0, 1'b1);
    // Point on a slanted edge.
    put_vertex(2, 2, 0, 0, 1'b1, 1'b0);
    put_vertex(0, 0, 4, 4, 1'b0, 1'b0);
    put_vertex(0, 0, 4, 0, 1'b0, 1'b0);
    put_vertex(0, 0, 0, 0, 1'b0, 1'b1);

    while (item_total < RANDOM_ITEMS + 22) begin
      add_polygon();
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (vertex_pending.size() != 0 || vertex_ch.valid) begin
      @(posedge clk);
    end
    while (inside_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0 && inside_expected.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #1000000;
    $display("FAILURE");
    $finish;
  end

endmodule
